// ----- sv/tdpt_pkg.sv -----
// Shared constants and types for the trial-division prime test unit.
package tdpt_pkg;

	localparam int unsigned NUMBER_BITS_DEF = 31;

	// status of the shared remainder unit, seen by the sequencer
	typedef struct packed {
		logic done;      // one-cycle pulse: remainder and quotient are valid
		logic rem_zero;  // remainder is zero
	} tdpt_div_status_t;

endpackage

// ----- sv/tdpt_div.sv -----
// Shared restoring divider: one quotient bit per cycle, gives remainder-zero and quotient.
module tdpt_div import tdpt_pkg::*; #(
	parameter int unsigned WIDTH = NUMBER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WIDTH-1:0]     dividend,
	input  logic [WIDTH-1:0]     divisor,
	output tdpt_div_status_t     status,
	output logic [WIDTH-1:0]     quot
);

	localparam int unsigned CNT_W = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dvd_q;   // dividend bits shift out at the top, quotient bits in at the bottom
	logic [WIDTH-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             qbit;

	assign trial = {rem_q, dvd_q[WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign qbit  = ~diff[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			dvd_q <= {dvd_q[WIDTH-2:0], qbit};
		end
	end

	assign status.done     = done_q;
	assign status.rem_zero = (rem_q == '0);
	assign quot            = dvd_q;

endmodule

// ----- sv/trial_division_prime_test_unit.sv -----
// Top level of the trial-division prime test: sequencer, result register, divider instance.
//
// Usage:
//   Input channel (in_valid/in_ready, number) takes one word: an unsigned integer.
//   Output channel (out_valid/out_ready, is_prime) returns one word per input:
//   1 when the number is prime, 0 otherwise (0 and 1 report 0).
//   in_ready is high only while the sequencer is idle; one number is tested at a time.
//   For 0, 1, 2, 3 and even numbers no division runs: the sequencer goes to its hold
//   state, then out_valid rises and in_ready comes back in the same cycle.
//   An odd number n >= 5 runs odd divisors d = 3, 5, 7, ... through the shared
//   restoring divider; each divisor takes a load, one quotient bit per cycle and a
//   decide step. The loop ends at the first zero remainder or when d exceeds the quotient
//   n / d, so a prime runs every odd divisor up to about sqrt(n).
//   The divider's single subtract-compare per cycle sets the cost of each divisor.
//   The result sits in an output register; a new number is accepted while it waits.
//   If the receiver stalls and a second result is ready, the sequencer holds it and
//   stays busy until the output register frees up.
//   Reset (arst_n low) returns the sequencer and the divider to idle and drops out_valid;
//   the number, divisor, result and divider data registers are not reset.
module trial_division_prime_test_unit import tdpt_pkg::*; #(
	parameter int unsigned NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [NUMBER_BITS-1:0] number,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   is_prime
);

	localparam int unsigned W = NUMBER_BITS;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	state_t           state_q;
	logic [W-1:0]     n_q;       // number under test
	logic [W-1:0]     d_q;       // current trial divisor
	logic             start_q;   // kicks the divider
	logic             res_q;     // finished result waiting for the output register
	logic             out_vld_q;
	logic             out_bit_q;

	tdpt_div_status_t div_st;
	logic [W-1:0]     div_quot;
	logic             out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;
	assign is_prime  = out_bit_q;

	tdpt_div #(.WIDTH(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (n_q),
		.divisor  (d_q),
		.status   (div_st),
		.quot     (div_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						// small numbers and even numbers need no division
						if (number <= W'(3) || !number[0]) begin
							state_q <= S_HOLD;
						end else begin
							state_q <= S_DIV;
							start_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						if (d_q > div_quot || div_st.rem_zero) begin
							state_q <= S_HOLD;
						end else begin
							start_q <= 1'b1;
						end
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath of the sequencer
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			n_q   <= number;
			d_q   <= W'(3);
			// two and three are prime; zero, one and even numbers are not
			res_q <= (number > W'(1)) && (number <= W'(3));
		end else if (state_q == S_DIV && div_st.done) begin
			if (d_q > div_quot) begin
				res_q <= 1'b1;   // passed sqrt(n) with no factor
			end else if (div_st.rem_zero) begin
				res_q <= 1'b0;
			end else begin
				d_q <= d_q + W'(2);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_HOLD && out_free) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HOLD && out_free) begin
			out_bit_q <= res_q;
		end
	end

endmodule

// ----- sv/tdpt_chk.sv -----
// Port-level checker for the prime test unit, with its bind.
module tdpt_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic is_prime
);

	// a stalled result word holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_prime))
		else $error("result word changed while stalled");

	// one number at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a test is running");

	// a new result word is loaded only from a busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a test in flight");

	// a result word never appears straight from idle with an empty output
	a_out_needs_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_ready |=> !out_valid)
		else $error("result appeared from idle");

endmodule

bind trial_division_prime_test_unit tdpt_chk u_chk (.*);

// ----- dv/trial_division_prime_test_unit_test.sv -----
// Self-checking testbench for the trial-division prime test unit.
`timescale 1ns / 1ps

// One outstanding word: the number as the block sees it and its verdict.
typedef struct {
	longint unsigned number;
	bit              prime;
} prime_verdict_t;

// Works out the verdict for each accepted number and checks returned words in order.
class prime_verdict_board;
	prime_verdict_t  verdicts[$];
	int unsigned     errors;
	int unsigned     checked;
	int unsigned     primes;
	longint unsigned largest;

	function new();
		errors  = 0;
		checked = 0;
		primes  = 0;
		largest = 0;
	endfunction

	// 0 and 1 are not prime, 2 and 3 are; evens fail; odd divisors run while d*d <= n.
	// Written as d <= n / d so the bound cannot overflow.
	function bit is_prime_number(longint unsigned n);
		longint unsigned d;
		if (n < 2)
			return 1'b0;
		if (n < 4)
			return 1'b1;
		if ((n & 64'd1) == 64'd0)
			return 1'b0;
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function void note_number(longint unsigned raw);
		prime_verdict_t v;
		v.number = raw & ((64'd1 << tdpt_pkg::NUMBER_BITS_DEF) - 64'd1);
		v.prime  = is_prime_number(v.number);
		verdicts.insert(verdicts.size(), v);
		if (v.number > largest)
			largest = v.number;
	endfunction

	function void check_verdict(logic got);
		prime_verdict_t v;
		if (verdicts.size() == 0) begin
			errors++;
			$display("%0t: is_prime=%b returned with no number outstanding", $time, got);
			return;
		end
		v = verdicts.pop_front();
		checked++;
		if (v.prime)
			primes++;
		if (got !== v.prime) begin
			errors++;
			$display("%0t: number %0d: is_prime expected %0b, actual %b",
				$time, v.number, v.prime, got);
		end
	endfunction

	function int unsigned outstanding();
		return verdicts.size();
	endfunction
endclass

module trial_division_prime_test_unit_test;
	import tdpt_pkg::*;

	localparam int unsigned     NB             = NUMBER_BITS_DEF;
	localparam longint unsigned MAX_NUMBER     = (64'd1 << NB) - 64'd1;
	// The Mersenne number 2^31-1 is prime and walks the whole divisor loop,
	// the slowest word here. Everything else is kept cheap, so CYCLE_LIMIT
	// leaves a wide margin over the slowest correct run.
	localparam int unsigned     CYCLE_LIMIT    = 6_000_000;
	localparam int unsigned     RANDOM_NUMBERS = 80;
	localparam int unsigned     PHASES         = 4;
	// Trivial cases need no division; the output register holds one word and the sequencer one more.
	localparam int unsigned     TAIL_CYCLES    = 20;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [NB-1:0] number;
	logic          out_valid;
	logic          out_ready;
	logic          is_prime;

	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;
	int unsigned cycles = 0;
	int unsigned sent;

	// idle mixes per random phase: none, sender gaps, receiver stalls, both light
	int unsigned sender_idle_by_phase   [PHASES] = '{0, 72, 0, 16};
	int unsigned receiver_stall_by_phase[PHASES] = '{0, 0, 72, 16};

	// Directed words: 0 and 1 (not prime), 2 and 3 (prime), small evens and odds,
	// squares of primes where the divisor bound is met exactly, a 16-bit prime,
	// a composite of small factors, a 20-bit prime, single top bit, all ones but
	// bit 0, a large multiple of 5, and the all-ones maximum (prime).
	longint unsigned directed_numbers[22] = '{
		0, 1, 2, 3, 4, 5, 7, 8, 9, 15, 25, 49, 121, 961, 97, 65521, 65535,
		999983, 64'd1073741824, 64'd2147483646, 64'd2147483645, 64'd2147483647};

	prime_verdict_board board;

	trial_division_prime_test_unit #(
		.NUMBER_BITS(NB)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.number   (number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_prime (is_prime)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: outputs are sampled at the edge before any update lands,
	// then ready is rerolled for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_verdict(is_prime);
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still outstanding",
				cycles, board.outstanding());
			$display("trial_division_prime_test_unit_test failed");
			$finish;
		end
	end

	// Mostly small numbers so the divisor loop stays short; a fifth are full-width
	// words forced to carry a factor of 13 or less, which keeps them cheap while
	// still toggling the upper bits.
	function automatic longint unsigned pick_number();
		int unsigned     roll;
		int unsigned     factor;
		longint unsigned x;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return $urandom_range(0, 4095);
		if (roll < 80)
			return $urandom_range(0, 1 << 18);
		x      = longint'($urandom) & MAX_NUMBER;
		factor = $urandom_range(2, 13);
		return x - (x % factor);
	endfunction

	// Entered in the step of the previous accept (or a free step); valid gets
	// exactly one update per step, so a back-to-back word keeps valid high.
	task automatic send_number(input longint unsigned n);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		number   <= n[NB-1:0];
		do
			@(posedge clk);
		while (!in_ready);
		board.note_number(n);
		sent++;
	endtask

	// Hold the sender off until every outstanding word has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.outstanding() != 0);
	endtask

	initial begin
		int unsigned phase;
		int unsigned k;

		board              = new();
		arst_n             = 1'b0;
		in_valid           = 1'b0;
		number             = '0;
		out_ready          = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		sent               = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words, no idling on either side
		foreach (directed_numbers[i])
			send_number(directed_numbers[i]);
		drain();

		// random words under each idle/stall mix, fully drained between phases
		for (phase = 0; phase < PHASES; phase++) begin
			sender_idle_pct    = sender_idle_by_phase[phase];
			receiver_stall_pct = receiver_stall_by_phase[phase];
			for (k = 0; k < RANDOM_NUMBERS / PHASES; k++)
				send_number(pick_number());
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d numbers sent, %0d verdicts checked (%0d prime), largest %0d;",
			sent, board.checked, board.primes, board.largest);
		$display("edge cases, prime squares and random sizes under four idle/stall mixes");
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("trial_division_prime_test_unit_test passed");
		end else begin
			$display("trial_division_prime_test_unit_test failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/tdpt_pkg.sv
sv/tdpt_div.sv
sv/trial_division_prime_test_unit.sv
sv/tdpt_chk.sv
dv/trial_division_prime_test_unit_test.sv
